// ===== sv/lvpt_pkg.sv =====
// ----------------------------------------------------------------------------
// lvpt_pkg
// Shared types and constants for the last-value predictor table.
// ----------------------------------------------------------------------------
package lvpt_pkg;

    localparam int PC_W    = 64;
    localparam int VALUE_W = 64;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_COUNTER_BITS      = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_ON_MISMATCH = 1'd1;

    localparam logic [CFG_DATA_W-1:0] COUNTER_BITS_RESET = 4'd3;

    // Operation codes
    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    // Value that never counts as a match
    localparam logic [VALUE_W-1:0] INVALID_MARKER = 64'h0000_0000_dead_beef;

    typedef struct packed {
        logic               operation;
        logic [1:0]         thread_id;
        logic [PC_W-1:0]    pc;
        logic [VALUE_W-1:0] actual_value;
    } in_item_t;

    typedef struct packed {
        logic               prediction_valid;
        logic [VALUE_W-1:0] predicted_value;
        logic               entry_hit;
    } out_item_t;

endpackage

// ===== sv/lvpt_slot_table.sv =====
// ----------------------------------------------------------------------------
// lvpt_slot_table
// Single-port-write, registered-read slot store with a clearing sweep that
// zeroes every word after reset.
// ----------------------------------------------------------------------------
module lvpt_slot_table #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 137,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    output logic              busy
);

    logic [WIDTH-1:0]  mem [DEPTH];
    logic [WIDTH-1:0]  rd_data_reg;
    logic              busy_reg;
    logic              busy_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    // Sweep one word per cycle, then drop busy
    always_comb
    begin
        busy_next     = busy_reg;
        clr_addr_next = clr_addr_reg;
        if (busy_reg)
        begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                busy_next = 1'b0;
            else
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
            mem[clr_addr_reg] <= '0;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// ===== sv/last_value_predictor_table.sv =====
// ----------------------------------------------------------------------------
// last_value_predictor_table
// Per-thread direct-mapped last-value predictor with saturating confidence.
// ----------------------------------------------------------------------------
// Takes one transfer per cycle on in_data while out_ready is held high and
// returns exactly one result per item, in order.
// The slot store has a registered read port: the slot is
// read at the accepting edge, the result stage then compares, builds the result and
// writes the slot back, and the result sits in the output register. A
// back-to-back item to the same slot takes the freshly written word through
// a bypass register. After reset all THREADS * TABLE_ENTRIES words of the
// store (4096 with the defaults) are swept clear; in_ready stays low
// until the sweep ends, while configuration writes are taken as usual.
// TABLE_ENTRIES must be a power of two: the slot index is the low pc bits and
// the stored tag is the rest of the address. A stalled output holds the
// pipeline, and in_ready drops only during the sweep or when the result stage cannot move on.
module last_value_predictor_table
    import lvpt_pkg::*;
#(
    parameter int TABLE_ENTRIES    = 1024,
    parameter int THREADS          = 4,
    parameter int MAX_COUNTER_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH   = THREADS * TABLE_ENTRIES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int TAG_W   = PC_W - IDX_W;
    localparam int CONF_W  = MAX_COUNTER_BITS;
    localparam int ENTRY_W = 1 + TAG_W + VALUE_W + CONF_W;

    // Slot word layout: {valid, tag, value, confidence}
    localparam int CONF_LO  = 0;
    localparam int VALUE_LO = CONF_W;
    localparam int TAG_LO   = CONF_W + VALUE_W;
    localparam int VALID_B  = ENTRY_W - 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] counter_bits_reg;
    logic                  clear_on_mismatch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_bits_reg      <= COUNTER_BITS_RESET;
            clear_on_mismatch_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COUNTER_BITS:      counter_bits_reg      <= cfg_data;
                REG_CLEAR_ON_MISMATCH: clear_on_mismatch_reg <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    // Saturation level: all ones at the clamped counter width
    logic [4:0]        bits_eff;
    logic [CONF_W-1:0] conf_max;

    always_comb
    begin
        priority if (counter_bits_reg == '0)
            bits_eff = 5'd1;
        else if (int'(counter_bits_reg) > MAX_COUNTER_BITS)
            bits_eff = 5'(MAX_COUNTER_BITS);
        else
            bits_eff = {1'b0, counter_bits_reg};
        conf_max = CONF_W'((17'd1 << bits_eff) - 17'd1);
    end

    // ------------------------------------------------------------------
    // Accept side and slot read
    // ------------------------------------------------------------------
    logic               in_fire;
    logic               in_thread_ok;
    logic [ADDR_W-1:0]  in_addr;
    logic               store_busy;
    logic [ENTRY_W-1:0] rd_entry;

    logic               s1_valid_reg;
    in_item_t           s1_item_reg;
    logic               s1_thread_ok_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic               s1_fire;

    logic               fwd_reg;
    logic [ENTRY_W-1:0] fwd_entry_reg;

    logic               wr_en;
    logic [ENTRY_W-1:0] wr_entry;

    logic               out_valid_reg;
    out_item_t          out_data_reg;
    out_item_t          result;

    assign in_thread_ok = int'(in_data.thread_id) < THREADS;
    assign in_addr      = ADDR_W'({in_data.thread_id, in_data.pc[IDX_W-1:0]});

    // Advance the result stage when the output register is free or draining
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !store_busy && (!s1_valid_reg || s1_fire);
    assign in_fire  = in_valid && in_ready;

    lvpt_slot_table #(
        .DEPTH (DEPTH),
        .WIDTH (ENTRY_W)
    ) u_slot_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire && in_thread_ok),
        .rd_addr (in_addr),
        .rd_data (rd_entry),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_entry),
        .busy    (store_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    // Payload of the result stage; the bypass flag marks a read that missed
    // the write-back landing on the same edge
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg      <= in_data;
            s1_thread_ok_reg <= in_thread_ok;
            s1_addr_reg      <= in_addr;
            fwd_reg          <= wr_en && (s1_addr_reg == in_addr);
            fwd_entry_reg    <= wr_entry;
        end
    end

    // ------------------------------------------------------------------
    // Compare, predict and build the write-back word
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] cur_entry;
    logic               cur_valid;
    logic [TAG_W-1:0]   cur_tag;
    logic [VALUE_W-1:0] cur_value;
    logic [CONF_W-1:0]  cur_conf;
    logic [CONF_W-1:0]  clamped_conf;
    logic [CONF_W-1:0]  new_conf;
    logic [VALUE_W-1:0] new_value;
    logic               hit;
    logic               value_match;

    always_comb
    begin
        cur_entry = fwd_reg ? fwd_entry_reg : rd_entry;
        cur_valid = cur_entry[VALID_B];
        cur_tag   = cur_entry[TAG_LO +: TAG_W];
        cur_value = cur_entry[VALUE_LO +: VALUE_W];
        cur_conf  = cur_entry[CONF_LO +: CONF_W];

        hit = s1_thread_ok_reg && cur_valid
            && (cur_tag == s1_item_reg.pc[PC_W-1:IDX_W]);
        value_match = (s1_item_reg.actual_value != INVALID_MARKER)
            && (s1_item_reg.actual_value == cur_value);

        clamped_conf = (cur_conf > conf_max) ? conf_max : cur_conf;

        priority if (!hit)
        begin
            new_conf  = '0;
            new_value = s1_item_reg.actual_value;
        end
        else if (value_match)
        begin
            new_conf  = (cur_conf >= conf_max) ? conf_max : cur_conf + CONF_W'(1);
            new_value = cur_value;
        end
        else
        begin
            if (clear_on_mismatch_reg)
                new_conf = '0;
            else
                new_conf = (clamped_conf != '0) ? clamped_conf - CONF_W'(1) : '0;
            new_value = s1_item_reg.actual_value;
        end

        wr_entry = {1'b1, s1_item_reg.pc[PC_W-1:IDX_W], new_value, new_conf};
        wr_en    = s1_fire && s1_thread_ok_reg && (s1_item_reg.operation == OP_UPDATE);

        result.entry_hit        = hit;
        result.prediction_valid = hit && (s1_item_reg.operation == OP_PREDICT)
                                  && (cur_conf >= conf_max);
        result.predicted_value  = result.prediction_valid ? cur_value : '0;
    end

    // ------------------------------------------------------------------
    // Output register: hold until the transfer completes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/lvpt_checker.sv =====
// ----------------------------------------------------------------------------
// lvpt_port_checker
// Port-level checks for the last-value predictor table, bound to the top.
// ----------------------------------------------------------------------------
module lvpt_port_checker
    import lvpt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // A prediction is only offered on a matching slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.prediction_valid |-> out_data.entry_hit)
        else $error("prediction without entry hit");

    // Drive zero when no prediction is offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.prediction_valid |-> out_data.predicted_value == '0)
        else $error("predicted value not zero without prediction");

    // Refuse transfers when reset is released and the store's sweep begins
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready && !out_valid)
        else $error("ready or result during clearing sweep");

endmodule

bind last_value_predictor_table lvpt_port_checker u_lvpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/lvpt_checker.sv =====
// ----------------------------------------------------------------------------
// lvpt_checker
// Watches both channels and the register port of the last-value predictor
// table, keeps a shadow of every thread's slots and compares each result
// transfer, field by field, against the shadow's answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lvpt_checker
    import lvpt_pkg::*;
#(
    parameter int TABLE_ENTRIES    = 1024,
    parameter int THREADS          = 4,
    parameter int MAX_COUNTER_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  in_item_t               in_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  out_item_t              out_data,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     outstanding,
    output int                     hits_seen,
    output int                     confident_seen
);

    localparam int SLOT_BITS = $clog2(TABLE_ENTRIES);

    typedef logic [MAX_COUNTER_BITS-1:0] conf_t;

    // Shadow slots, one table per thread
    logic               slot_live [THREADS][TABLE_ENTRIES];
    logic [PC_W-1:0]    slot_tag  [THREADS][TABLE_ENTRIES];
    logic [VALUE_W-1:0] slot_data [THREADS][TABLE_ENTRIES];
    conf_t              slot_conf [THREADS][TABLE_ENTRIES];

    logic [CFG_DATA_W-1:0] width_reg;
    logic                  clear_reg;

    out_item_t pending_results [$];
    out_item_t want;
    int        fail_tally;
    int        hit_tally;
    int        confident_tally;

    // All-ones value of the effective counter width (clamped to 1..max)
    function automatic conf_t saturation_level();
        int bits;
        bits = width_reg;
        if (bits < 1)
            bits = 1;
        if (bits > MAX_COUNTER_BITS)
            bits = MAX_COUNTER_BITS;
        return conf_t'((1 << bits) - 1);
    endfunction

    // Look up and, for an update, train the slot; return the answer
    function automatic out_item_t train_and_lookup(input in_item_t item);
        out_item_t        res;
        conf_t            ceiling;
        conf_t            c;
        logic [SLOT_BITS-1:0] slot;
        logic             hit;
        res = '0;
        if (item.thread_id >= THREADS)
            return res;
        ceiling = saturation_level();
        slot    = item.pc[SLOT_BITS-1:0];
        hit     = slot_live[item.thread_id][slot]
                  && slot_tag[item.thread_id][slot] == item.pc;
        c       = slot_conf[item.thread_id][slot];
        res.entry_hit = hit;
        if (item.operation == OP_PREDICT) begin
            if (hit && c >= ceiling) begin
                res.prediction_valid = 1'b1;
                res.predicted_value  = slot_data[item.thread_id][slot];
            end
        end
        else if (!hit) begin
            slot_live[item.thread_id][slot] = 1'b1;
            slot_tag[item.thread_id][slot]  = item.pc;
            slot_data[item.thread_id][slot] = item.actual_value;
            slot_conf[item.thread_id][slot] = '0;
        end
        else if (item.actual_value != INVALID_MARKER
                 && item.actual_value == slot_data[item.thread_id][slot]) begin
            slot_conf[item.thread_id][slot] = (c >= ceiling) ? ceiling : c + 1'b1;
        end
        else begin
            if (clear_reg) begin
                slot_conf[item.thread_id][slot] = '0;
            end
            else begin
                // clamp a counter left over from a wider setting first
                if (c > ceiling)
                    c = ceiling;
                slot_conf[item.thread_id][slot] = (c != '0) ? c - 1'b1 : '0;
            end
            slot_data[item.thread_id][slot] = item.actual_value;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int t = 0; t < THREADS; t++)
                for (int s = 0; s < TABLE_ENTRIES; s++)
                    slot_live[t][s] = 1'b0;
            width_reg       = COUNTER_BITS_RESET;
            clear_reg       = 1'b1;
            pending_results.delete();
            fail_tally      = 0;
            hit_tally       = 0;
            confident_tally = 0;
        end
        else begin
            if (cfg_write) begin
                if (cfg_index == REG_COUNTER_BITS)
                    width_reg = cfg_data;
                else if (cfg_index == REG_CLEAR_ON_MISMATCH)
                    clear_reg = cfg_data[0];
            end
            // retire the oldest result before taking the new item
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with nothing outstanding: %p", out_data);
                    fail_tally++;
                end
                else begin
                    want = pending_results.pop_front();
                    if (out_data.prediction_valid !== want.prediction_valid) begin
                        $error("prediction_valid: expected %0d, actual %0d",
                               want.prediction_valid, out_data.prediction_valid);
                        fail_tally++;
                    end
                    if (out_data.predicted_value !== want.predicted_value) begin
                        $error("predicted_value: expected %h, actual %h",
                               want.predicted_value, out_data.predicted_value);
                        fail_tally++;
                    end
                    if (out_data.entry_hit !== want.entry_hit) begin
                        $error("entry_hit: expected %0d, actual %0d",
                               want.entry_hit, out_data.entry_hit);
                        fail_tally++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                want = train_and_lookup(in_data);
                hit_tally       += want.entry_hit;
                confident_tally += want.prediction_valid;
                pending_results.push_back(want);
            end
        end
        mismatches     <= fail_tally;
        outstanding    <= pending_results.size();
        hits_seen      <= hit_tally;
        confident_seen <= confident_tally;
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the last-value predictor table: a directed run
// through allocation, training, confident lookup, invalid-marker updates,
// slot replacement and counter-width shrink, then random training bursts
// and noise under six register settings and three idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
    import lvpt_pkg::*;
();

    localparam int TABLE_ENTRIES    = 1024;
    localparam int THREADS          = 4;
    localparam int MAX_COUNTER_BITS = 8;
    localparam int SLOT_BITS        = $clog2(TABLE_ENTRIES);

    // Address pool: the last ALIASES entries share a slot with the first ones
    localparam int POOL_SIZE = 12;
    localparam int ALIASES   = 3;

    localparam int PHASES          = 6;
    localparam int PHASE_ITEMS     = 115;
    localparam int LONG_RUN        = 260;  // enough matches to fill an 8-bit counter
    localparam int HOLD_OFF_CYCLES = 40;
    localparam int SETTLE_CYCLES   = 6;
    // Longest quiet stretch is the post-reset sweep of all 4096 store words
    localparam int WATCHDOG_LIMIT  = 20000;

    // Register plan per random phase: counter width and mismatch policy
    localparam logic [PHASES*CFG_DATA_W-1:0] WIDTH_PLAN =
        {4'd1, 4'd3, 4'd8, 4'd2, 4'd15, 4'd0};
    localparam logic [PHASES-1:0] CLEAR_PLAN = 6'b100110;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_data;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_COUNTER_BITS;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int mismatches;
    int outstanding;
    int hits_seen;
    int confident_seen;

    int   items_sent    = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   quiet_cycles  = 0;
    logic hold_off_due  = 1'b0;
    bit   hold_off_done = 1'b0;

    logic [PC_W-1:0] pc_pool [POOL_SIZE];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    last_value_predictor_table #(
        .TABLE_ENTRIES   (TABLE_ENTRIES),
        .THREADS         (THREADS),
        .MAX_COUNTER_BITS(MAX_COUNTER_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    lvpt_checker #(
        .TABLE_ENTRIES   (TABLE_ENTRIES),
        .THREADS         (THREADS),
        .MAX_COUNTER_BITS(MAX_COUNTER_BITS)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .hits_seen     (hits_seen),
        .confident_seen(confident_seen)
    );

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic in_item_t make_item(input logic op, input logic [1:0] tid,
                                           input logic [PC_W-1:0] pc,
                                           input logic [VALUE_W-1:0] value);
        in_item_t item;
        item.operation    = op;
        item.thread_id    = tid;
        item.pc           = pc;
        item.actual_value = value;
        return item;
    endfunction

    // Offer one item and hold it until the transfer happens. Idle cycles go
    // in front of the item so that gaps land at any point of the pipeline.
    task automatic push_item(input in_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline
    // run dry before touching the registers.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] counter_width,
                              input logic clear_policy);
        cfg_write <= 1'b1;
        cfg_index <= REG_COUNTER_BITS;
        cfg_data  <= counter_width;
        @(posedge clk);
        cfg_index <= REG_CLEAR_ON_MISMATCH;
        cfg_data  <= CFG_DATA_W'(clear_policy);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // A well-formed training sequence: repeated updates of one address with
    // mostly the same value, lookups sprinkled in, and a lookup at the end.
    task automatic train_slot(input bit long_run);
        logic [1:0]         tid;
        logic [PC_W-1:0]    pc;
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] sent_value;
        int                 pick;
        int                 count;
        tid  = 2'($urandom_range(3));
        pc   = pc_pool[$urandom_range(POOL_SIZE - 1)];
        pick = $urandom_range(4);
        value = (pick == 0) ? '0 : (pick == 1) ? '1 :
                (pick == 2) ? INVALID_MARKER : random_word();
        if (long_run)
            value = random_word();
        count = long_run ? LONG_RUN : $urandom_range(12, 1);
        repeat (count)
        begin
            if ($urandom_range(4) == 0)
                push_item(make_item(OP_PREDICT, tid, pc, random_word()));
            pick = $urandom_range(99);
            sent_value = (long_run || pick < 85) ? value :
                         (pick < 92) ? INVALID_MARKER : random_word();
            push_item(make_item(OP_UPDATE, tid, pc, sent_value));
        end
        push_item(make_item(OP_PREDICT, tid, pc, random_word()));
    endtask

    // Anything goes: random operation, thread, address and value
    task automatic push_noise();
        in_item_t item;
        item.operation    = 1'($urandom_range(1));
        item.thread_id    = 2'($urandom_range(3));
        item.pc           = $urandom_range(1) ? pc_pool[$urandom_range(POOL_SIZE - 1)]
                                              : random_word();
        item.actual_value = ($urandom_range(3) == 0) ? INVALID_MARKER : random_word();
        push_item(item);
    endtask

    // Receiver: stall at random, and once take a long hold-off so the
    // pipeline fills and in_ready has to drop.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_due && !hold_off_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: count cycles in which neither channel moves a transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("last_value_predictor_table verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [63:0]             word;
        logic [PC_W-1:0]         addr_a;
        logic [PC_W-1:0]         addr_b;
        logic [VALUE_W-1:0]      val_a;
        logic [VALUE_W-1:0]      val_b;
        logic [VALUE_W-1:0]      val_c;
        int                      start;
        bit                      long_due;

        for (int i = 0; i < POOL_SIZE; i++)
        begin
            word = random_word();
            if (i >= POOL_SIZE - ALIASES)
                pc_pool[i] = {word[PC_W-1:SLOT_BITS],
                              pc_pool[i - (POOL_SIZE - ALIASES)][SLOT_BITS-1:0]};
            else
                pc_pool[i] = word;
        end

        addr_a = 64'h0123_4567_89ab_cdef;
        addr_b = 64'h7fff_0000_1234_0abc;
        val_a  = 64'hfedc_ba98_7654_3210;
        val_b  = 64'h0000_0001_0000_0001;
        val_c  = 64'h5555_aaaa_5555_aaaa;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: 2-bit counters, decrement on mismatch
        send_idle_pct = 22;
        recv_idle_pct = 72;
        write_regs(4'd2, 1'b0);

        // cold lookup, then allocate and train up to saturation
        push_item(make_item(OP_PREDICT, 2'd0, addr_a, '0));
        repeat (5) push_item(make_item(OP_UPDATE, 2'd0, addr_a, val_a));
        push_item(make_item(OP_PREDICT, 2'd0, addr_a, '0));
        // the invalid marker never matches, not even itself
        repeat (2) push_item(make_item(OP_UPDATE, 2'd0, addr_a, INVALID_MARKER));
        // same address, other thread: separate table
        push_item(make_item(OP_PREDICT, 2'd1, addr_a, '0));
        // extreme addresses and values; the top-bit address evicts slot zero
        push_item(make_item(OP_UPDATE, 2'd3, '1, '1));
        push_item(make_item(OP_UPDATE, 2'd3, '0, '0));
        push_item(make_item(OP_UPDATE, 2'd3, 64'h8000_0000_0000_0000, '1));
        push_item(make_item(OP_PREDICT, 2'd3, '0, '1));
        push_item(make_item(OP_PREDICT, 2'd3, '1, '0));
        // train to three, then shrink the counter to one bit
        repeat (4) push_item(make_item(OP_UPDATE, 2'd2, addr_b, val_b));
        settle();
        write_regs(4'd1, 1'b0);
        push_item(make_item(OP_PREDICT, 2'd2, addr_b, '0));
        push_item(make_item(OP_UPDATE, 2'd2, addr_b, val_b));
        push_item(make_item(OP_UPDATE, 2'd2, addr_b, val_c));
        push_item(make_item(OP_PREDICT, 2'd2, addr_b, '0));
        push_item(make_item(OP_UPDATE, 2'd2, addr_b, val_c));
        push_item(make_item(OP_PREDICT, 2'd2, addr_b, '0));

        // Random part: two phases per idling pattern
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_regs(WIDTH_PLAN[p*CFG_DATA_W +: CFG_DATA_W], CLEAR_PLAN[p]);
            send_idle_pct = (p < 2) ? 22 : (p < 4) ? 72 : 0;
            recv_idle_pct = (p < 2) ? 72 : (p < 4) ? 22 : 0;
            if (p == 4)
                hold_off_due <= 1'b1;
            // the 8-bit phase opens with one run long enough to saturate
            long_due = (WIDTH_PLAN[p*CFG_DATA_W +: CFG_DATA_W] == 4'd8);
            start    = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                if ($urandom_range(9) < 7)
                begin
                    train_slot(long_due);
                    long_due = 1'b0;
                end
                else
                begin
                    push_noise();
                end
            end
        end

        settle();
        $display("Covered %0d item transfers over eight register settings, four threads,",
                 items_sent);
        $display("aliased and extreme addresses: %0d slot hits, %0d confident predictions.",
                 hits_seen, confident_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("last_value_predictor_table verification clean");
        else
            $display("last_value_predictor_table verification failed");
        $finish;
    end

endmodule
